FILE: rtl/decaying_max_background_estimate_assert.svh
// assertion macros for the background estimate rtl
// no dependencies; included by the files that carry assertions
`ifndef DECAYING_MAX_BACKGROUND_ESTIMATE_ASSERT_SVH
`define DECAYING_MAX_BACKGROUND_ESTIMATE_ASSERT_SVH

// same-cycle implication
`define DMBE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define DMBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

FILE: rtl/dmbe_pkg.sv
// types, codes and arithmetic helpers for the background estimate block
// used by dmbe_controller, dmbe_datapath and the top level
`default_nettype none

package dmbe_pkg;

   localparam int PIXEL_W = 12;
   localparam int VALUE_W = 20;
   localparam int DECAY_W = 16;
   localparam int DIM_W   = 10;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_FACTOR = 2'd2;

   localparam logic [DIM_W-1:0]   RESET_WIDTH  = 10'd512;
   localparam logic [DIM_W-1:0]   RESET_HEIGHT = 10'd512;
   localparam logic [DECAY_W-1:0] RESET_DECAY  = 16'd64669;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_MEM,
      ST_MULTIPLY,
      ST_WRITE
   } state_type;

   typedef enum logic [1:0] {
      PASS_LEFT,
      PASS_RIGHT,
      PASS_UP
   } pass_type;

   typedef struct packed {
      logic     load;
      logic     read;
      logic     rd;
      logic     mul;
      logic     wr;
      logic     begin_right;
      logic     begin_up;
      logic     next_up;
      logic     set_complete;
      pass_type pass;
   } cmd_type;

   typedef struct packed {
      logic row_done;
      logic x_end;
      logic last_row;
      logic single_row;
      logic up_row_zero;
   } status_type;

   // (v * decay) >> 16, truncated
   function automatic logic [VALUE_W-1:0] decayed(input logic [VALUE_W-1:0] v,
                                                 input logic [DECAY_W-1:0] d);
      logic [VALUE_W+DECAY_W-1:0] p;
      begin
         p = {{DECAY_W{1'b0}}, v} * {{VALUE_W{1'b0}}, d};
         decayed = p[VALUE_W+DECAY_W-1:DECAY_W];
      end
   endfunction

   // 12.8 to integer, half up, saturated
   function automatic logic [PIXEL_W-1:0] round_level(input logic [VALUE_W-1:0] v);
      logic [VALUE_W:0] s;
      begin
         s = {1'b0, v} + (VALUE_W+1)'(128);
         round_level = s[VALUE_W] ? {PIXEL_W{1'b1}} : s[VALUE_W-1:8];
      end
   endfunction

endpackage

`default_nettype wire

FILE: rtl/dmbe_controller.sv
// sequencer for row passes, upward pass and command acceptance
// depends on dmbe_pkg and the assertion macro header
`default_nettype none
`include "decaying_max_background_estimate_assert.svh"

module dmbe_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 req_opcode,
   input  wire dmbe_pkg::status_type status,
   output dmbe_pkg::cmd_type         cmd,
   output logic                      busy
);

   dmbe_pkg::state_type state_ff, state_in;
   dmbe_pkg::pass_type  pass_ff, pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dmbe_pkg::ST_IDLE;
         pass_ff  <= dmbe_pkg::PASS_LEFT;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      cmd.pass = pass_ff;
      busy     = (state_ff != dmbe_pkg::ST_IDLE);
      unique case (state_ff)
         dmbe_pkg::ST_IDLE: begin
            if (start) begin
               if (req_opcode == dmbe_pkg::OP_LOAD) begin
                  cmd.load = 1'b1;
                  if (status.row_done) begin
                     pass_in  = dmbe_pkg::PASS_LEFT;
                     state_in = dmbe_pkg::ST_READ_MEM;
                  end
               end else begin
                  cmd.read = 1'b1;
               end
            end
         end
         dmbe_pkg::ST_READ_MEM: begin
            cmd.rd   = 1'b1;
            state_in = dmbe_pkg::ST_MULTIPLY;
         end
         dmbe_pkg::ST_MULTIPLY: begin
            cmd.mul  = 1'b1;
            state_in = dmbe_pkg::ST_WRITE;
         end
         dmbe_pkg::ST_WRITE: begin
            cmd.wr   = 1'b1;
            state_in = dmbe_pkg::ST_READ_MEM;
            if (status.x_end) begin
               unique case (pass_ff)
                  dmbe_pkg::PASS_LEFT: begin
                     cmd.begin_right = 1'b1;
                     pass_in         = dmbe_pkg::PASS_RIGHT;
                  end
                  dmbe_pkg::PASS_RIGHT: begin
                     priority if (!status.last_row) begin
                        state_in = dmbe_pkg::ST_IDLE;
                     end else if (status.single_row) begin
                        cmd.set_complete = 1'b1;
                        state_in         = dmbe_pkg::ST_IDLE;
                     end else begin
                        cmd.begin_up = 1'b1;
                        pass_in      = dmbe_pkg::PASS_UP;
                     end
                  end
                  dmbe_pkg::PASS_UP: begin
                     if (status.up_row_zero) begin
                        cmd.set_complete = 1'b1;
                        state_in         = dmbe_pkg::ST_IDLE;
                     end else begin
                        cmd.next_up = 1'b1;
                     end
                  end
                  default: state_in = dmbe_pkg::ST_IDLE;
               endcase
            end
         end
         default: state_in = dmbe_pkg::ST_IDLE;
      endcase
   end

   `DMBE_ASSERT_NEXT(a_mul_after_rd, clock, reset, cmd.rd, cmd.mul)
   `DMBE_ASSERT_NEXT(a_wr_after_mul, clock, reset, cmd.mul, cmd.wr)
   `DMBE_ASSERT_NEXT(a_idle_after_complete, clock, reset, cmd.set_complete, !busy)
   `DMBE_ASSERT_IMPL(a_up_only_on_last_row, clock, reset, cmd.begin_up, status.last_row)

endmodule

`default_nettype wire

FILE: rtl/dmbe_datapath.sv
// row, neighbor and frame memories, position counters and the decay arithmetic
// depends on dmbe_pkg; driven by dmbe_controller commands
`default_nettype none

module dmbe_datapath #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dmbe_pkg::cmd_type             cmd,
   input  wire logic [dmbe_pkg::PIXEL_W-1:0]  req_pixel,
   input  wire logic                          csr_write_enable,
   input  wire logic [dmbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [dmbe_pkg::CSR_W-1:0]    csr_write_data,
   output dmbe_pkg::status_type               status,
   output logic                               rsp_strobe,
   output logic [dmbe_pkg::PIXEL_W-1:0]       rsp_level,
   output logic                               rsp_last_pixel,
   output logic                               rsp_not_ready
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TW    = WW + HW;
   localparam int VW    = dmbe_pkg::VALUE_W;
   localparam int PW    = dmbe_pkg::PIXEL_W;

   logic [VW-1:0] cur_mem [MAX_WIDTH];
   logic [VW-1:0] nb_mem  [MAX_WIDTH];
   logic [PW-1:0] fs_mem  [DEPTH];

   logic [dmbe_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic [dmbe_pkg::DECAY_W-1:0] decay_ff;
   logic [WW-1:0] col_ff;
   logic [HW-1:0] row_ff;
   logic [AW-1:0] readout_ff;
   logic          complete_ff;
   logic [WW-1:0] x_ff;
   logic [HW-1:0] prow_ff;
   logic          first_ff, above_ff, last_row_ff;
   logic [VW-1:0] cur_q_ff, nb_q_ff, prev_ff, prod_l_ff, prod_n_ff;
   logic [PW-1:0] fs_q_ff;
   logic          rsp_strobe_ff, rsp_last_ff, rsp_nr_ff;

   logic [WW-1:0] eff_w, w_last, col_c;
   logic [HW-1:0] eff_h, h_last, row_c;
   logic [TW-1:0] total;
   logic [AW-1:0] idx_c, proc_addr, fs_raddr;
   logic          idx_last;
   logic [VW-1:0] src, chained, final_v;
   logic          use_nb;

   always_comb begin
      if (width_ff == '0) eff_w = WW'(1);
      else if (32'(width_ff) > 32'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
      else eff_w = WW'(width_ff);
      if (height_ff == '0) eff_h = HW'(1);
      else if (32'(height_ff) > 32'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
      else eff_h = HW'(height_ff);
      w_last = eff_w - WW'(1);
      h_last = eff_h - HW'(1);
      col_c  = complete_ff ? '0 : ((col_ff > w_last) ? w_last : col_ff);
      row_c  = complete_ff ? '0 : ((row_ff > h_last) ? h_last : row_ff);
      total  = TW'(eff_w) * TW'(eff_h);
      idx_c  = (TW'(readout_ff) >= total) ? '0 : readout_ff;
      idx_last  = (TW'(idx_c) == total - TW'(1));
      proc_addr = AW'(TW'(prow_ff) * TW'(eff_w) + TW'(x_ff));
      fs_raddr  = cmd.read ? idx_c : proc_addr;
   end

   always_comb begin
      status.row_done    = (col_c == w_last);
      status.x_end       = (cmd.pass == dmbe_pkg::PASS_RIGHT) ? (x_ff == '0)
                                                              : (x_ff == w_last);
      status.last_row    = last_row_ff;
      status.single_row  = (eff_h == HW'(1));
      status.up_row_zero = (prow_ff == '0);
   end

   // combine step for the element whose memory data arrived
   always_comb begin
      src = (cmd.pass == dmbe_pkg::PASS_UP) ? {fs_q_ff, 8'd0} : cur_q_ff;
      if (cmd.pass != dmbe_pkg::PASS_UP && !first_ff && prod_l_ff > src) chained = prod_l_ff;
      else chained = src;
      use_nb  = (cmd.pass == dmbe_pkg::PASS_UP) ||
                (cmd.pass == dmbe_pkg::PASS_RIGHT && above_ff);
      final_v = (use_nb && prod_n_ff > chained) ? prod_n_ff : chained;
   end

   // memories
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_mem[col_c[XW-1:0]] <= {req_pixel, 8'd0};
      end else if (cmd.wr && cmd.pass == dmbe_pkg::PASS_LEFT) begin
         cur_mem[x_ff[XW-1:0]] <= chained;
      end
      if (cmd.rd) begin
         cur_q_ff <= cur_mem[x_ff[XW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr && cmd.pass != dmbe_pkg::PASS_LEFT) begin
         nb_mem[x_ff[XW-1:0]] <= final_v;
      end
      if (cmd.rd) begin
         nb_q_ff <= nb_mem[x_ff[XW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr && cmd.pass != dmbe_pkg::PASS_LEFT) begin
         fs_mem[proc_addr] <= dmbe_pkg::round_level(final_v);
      end
      if (cmd.read || cmd.rd) begin
         fs_q_ff <= fs_mem[fs_raddr];
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_l_ff <= dmbe_pkg::decayed(prev_ff, decay_ff);
         prod_n_ff <= dmbe_pkg::decayed(nb_q_ff, decay_ff);
      end
      if (cmd.wr) begin
         prev_ff <= chained;
      end
      if (cmd.load && status.row_done) begin
         above_ff    <= (row_c != '0);
         last_row_ff <= (row_c == h_last);
      end
   end

   // pass position
   always_ff @(posedge clock) begin
      priority if (cmd.load && status.row_done) begin
         x_ff     <= '0;
         first_ff <= 1'b1;
         prow_ff  <= row_c;
      end else if (cmd.begin_right) begin
         x_ff     <= w_last;
         first_ff <= 1'b1;
      end else if (cmd.begin_up) begin
         x_ff     <= '0;
         first_ff <= 1'b1;
         prow_ff  <= eff_h - HW'(2);
      end else if (cmd.next_up) begin
         x_ff     <= '0;
         first_ff <= 1'b1;
         prow_ff  <= prow_ff - HW'(1);
      end else if (cmd.wr) begin
         first_ff <= 1'b0;
         x_ff     <= (cmd.pass == dmbe_pkg::PASS_RIGHT) ? x_ff - WW'(1) : x_ff + WW'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= dmbe_pkg::RESET_WIDTH;
         height_ff     <= dmbe_pkg::RESET_HEIGHT;
         decay_ff      <= dmbe_pkg::RESET_DECAY;
         col_ff        <= '0;
         row_ff        <= '0;
         readout_ff    <= '0;
         complete_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               dmbe_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data[dmbe_pkg::DIM_W-1:0];
               dmbe_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_write_data[dmbe_pkg::DIM_W-1:0];
               dmbe_pkg::CSR_DECAY_FACTOR: decay_ff  <= csr_write_data;
               default: ;
            endcase
         end
         rsp_strobe_ff <= cmd.read;
         if (cmd.load) begin
            if (complete_ff) begin
               complete_ff <= 1'b0;
               readout_ff  <= '0;
            end
            if (status.row_done) begin
               col_ff <= '0;
               row_ff <= (row_c == h_last) ? '0 : row_c + HW'(1);
            end else begin
               col_ff <= col_c + WW'(1);
               row_ff <= row_c;
            end
         end else if (cmd.read && complete_ff) begin
            readout_ff <= idx_last ? '0 : idx_c + AW'(1);
         end else if (cmd.set_complete) begin
            complete_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rsp_nr_ff   <= !complete_ff;
         rsp_last_ff <= complete_ff && idx_last;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_level      = rsp_nr_ff ? '0 : fs_q_ff;
   assign rsp_last_pixel = rsp_last_ff;
   assign rsp_not_ready  = rsp_nr_ff;

endmodule

`default_nettype wire

FILE: rtl/decaying_max_background_estimate.sv
// top level of the decaying-max background light estimator
// instantiates dmbe_controller and dmbe_datapath; types from dmbe_pkg
//
// usage: raise start with req_opcode/req_pixel while busy is low; the
// transaction is taken at that edge. a load (opcode 0) stores the next
// pixel in raster order and leaves busy low, except the load that ends a
// row: it keeps busy high through a left pass, then a right pass with
// the row above, each pixel stepping through the read, multiply and
// write states via the row memories and the decay multiplier. the load
// ending the last row also runs the upward pass over the frame memory.
// a read (opcode 1) never raises busy; its result shows on rsp_* with
// rsp_strobe for one cycle, the cycle after the read is taken (one frame
// memory read). reads may go back to back.
// before the frame is complete a read returns rsp_not_ready with level 0.
// the receiver cannot stall: a result is lost if not taken in its cycle.
// reset (synchronous) restores the csr registers and empties the
// position and readout counters; no memory clearing pass is run.
// csr writes are taken at any edge with csr_write_enable high.
`default_nettype none

module decaying_max_background_estimate #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_opcode,
   input  wire logic [dmbe_pkg::PIXEL_W-1:0]    req_pixel,
   output logic                                 rsp_strobe,
   output logic [dmbe_pkg::PIXEL_W-1:0]         rsp_level,
   output logic                                 rsp_last_pixel,
   output logic                                 rsp_not_ready,
   input  wire logic                            csr_write_enable,
   input  wire logic [dmbe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [dmbe_pkg::CSR_W-1:0]      csr_write_data
);

   dmbe_pkg::cmd_type    cmd;
   dmbe_pkg::status_type status;

   dmbe_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   dmbe_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_pixel        (req_pixel),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_level        (rsp_level),
      .rsp_last_pixel   (rsp_last_pixel),
      .rsp_not_ready    (rsp_not_ready)
   );

endmodule

`default_nettype wire
